>>> hdl/ekc_pkg.sv
// Shared types, constants and the kernel function of the strided edge convolver.
// Used by every module but ekc_ram and by the stream interfaces; depends on nothing.
`default_nettype none

package ekc_pkg;

   localparam int PIXEL_W = 8;
   localparam int SUM_W = 11;
   localparam int ROW_W = 10;
   localparam int WIDTH_REG_W = 8;
   localparam int HEIGHT_REG_W = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_INDEX_W = 2;

   localparam int MAX_WIDTH_DEFAULT = 128;
   localparam int WIDTH_MIN = 2;
   localparam int HEIGHT_MIN = 2;
   localparam int HEIGHT_MAX = 1024;
   localparam int RESET_HEIGHT = 128;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef logic [PIXEL_W-1:0] pixel_type;
   // One window column: index 0 is the top row, index 2 the bottom row.
   typedef logic [2:0][PIXEL_W-1:0] column_type;
   typedef logic signed [1:0] weight_type;

   // Sum of the edge kernels, folded together into this kernel.
   localparam weight_type KERNEL [0:2][0:2] = '{
      '{-2'sd1, 2'sd1, 2'sd1},
      '{-2'sd1, 2'sd0, 2'sd1},
      '{-2'sd1, -2'sd1, 2'sd1}
   };

   // Per-item control that travels with a pixel from the read stage to the window stage.
   typedef struct packed {
      logic flush;
      logic emit_row;
      logic col_even_ge2;
      logic col_odd;
      logic last_col;
      logic last_row;
   } item_ctl_type;

   function automatic logic signed [SUM_W:0] weigh(input pixel_type pix, input weight_type w);
      logic signed [SUM_W:0] ext;
      ext = $signed({{(SUM_W + 1 - PIXEL_W){1'b0}}, pix});
      if (w == 2'sd1) begin
         return ext;
      end else if (w == -2'sd1) begin
         return -ext;
      end else begin
         return '0;
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] apply_kernel(input column_type lft,
                                                           input column_type mid,
                                                           input column_type rgt);
      logic signed [SUM_W:0] acc;
      int r;
      acc = '0;
      for (r = 0; r < 3; r++) begin
         acc = acc + weigh(lft[r], KERNEL[r][0]) + weigh(mid[r], KERNEL[r][1])
                   + weigh(rgt[r], KERNEL[r][2]);
      end
      // The response stays within +/-1020, so the top bit is a pure sign copy.
      return acc[SUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/ekc_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the edge result output.
// Payload widths come from ekc_pkg.
`default_nettype none

interface ekc_pix_if;
   logic valid;
   logic ready;
   logic [ekc_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface ekc_res_if;
   logic valid;
   logic ready;
   logic signed [ekc_pkg::SUM_W-1:0] edge_sum;
   logic row_end;
   logic frame_end;

   modport source (output valid, output edge_sum, output row_end, output frame_end,
                   input ready);
   modport sink (input valid, input edge_sum, input row_end, input frame_end,
                 output ready);
endinterface

`default_nettype wire

>>> hdl/ekc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; no package dependencies.
`default_nettype none

module ekc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire                      re,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/ekc_window.sv
// Window stage: two column registers, the kernel datapath and the output flags.
// Depends on ekc_pkg for the column type, the item control struct and apply_kernel.
`default_nettype none

module ekc_window (
   input  wire                                 clock,
   input  wire                                 advance,
   input  ekc_pkg::item_ctl_type               item,
   input  wire [ekc_pkg::PIXEL_W-1:0]          top_pix,
   input  wire [ekc_pkg::PIXEL_W-1:0]          mid_pix,
   input  wire [ekc_pkg::PIXEL_W-1:0]          bot_pix,
   output logic                                has_result,
   output logic signed [ekc_pkg::SUM_W-1:0]    edge_sum,
   output logic                                row_end,
   output logic                                frame_end
);

   ekc_pkg::column_type left_ff, left_in;
   ekc_pkg::column_type mid_ff, mid_in;
   ekc_pkg::column_type cur;
   ekc_pkg::column_type sel_l, sel_m, sel_r;

   always_comb begin
      cur[0] = top_pix;
      cur[1] = mid_pix;
      // During the end-of-frame sweep the row below the image counts as zero.
      cur[2] = item.flush ? '0 : bot_pix;
   end

   always_comb begin
      left_in = left_ff;
      mid_in = mid_ff;
      if (advance) begin
         left_in = mid_ff;
         mid_in = cur;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      mid_ff <= mid_in;
   end

   // A centre on an odd column is complete when its right column arrives. At the right
   // edge of an even-width row the last centre has no right column and is closed early.
   always_comb begin
      if (item.col_even_ge2) begin
         sel_l = left_ff;
         sel_m = mid_ff;
         sel_r = cur;
      end else begin
         sel_l = mid_ff;
         sel_m = cur;
         sel_r = '0;
      end
   end

   assign has_result = item.emit_row && (item.col_even_ge2 || (item.last_col && item.col_odd));
   assign edge_sum = ekc_pkg::apply_kernel(sel_l, sel_m, sel_r);
   assign row_end = item.col_even_ge2 ? item.last_col : 1'b1;
   assign frame_end = row_end && item.last_row;

endmodule

`default_nettype wire

>>> hdl/edge_kernel_conv3x3_stride2.sv
// Stride-2 3x3 edge convolver over a raster pixel stream. One pixel is taken per clock
// unless the output stalls; a result passes the window stage and output registers after the
// pixel that completes its window. Both line buffers live in one RAM entry per column, read
// and rewritten once per pixel. At an even frame height the last pixel starts a sweep over
// every column of the clamped width, stalling with the output, that reads the last two rows
// back from that RAM to emit the last output row; no pixel is taken during the sweep. A width
// or height write restarts the frame. The line buffer RAM needs no clearing after reset.
`default_nettype none

module edge_kernel_conv3x3_stride2 #(
   parameter int MAX_WIDTH = ekc_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   ekc_pix_if.sink                              req_bus,
   ekc_res_if.source                            rsp_bus,
   input  wire                                  csr_we,
   input  wire [ekc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [ekc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = COL_W + 1;
   localparam int HGT_W = ekc_pkg::HEIGHT_REG_W;
   localparam int ROW_W = ekc_pkg::ROW_W;
   localparam int PW = ekc_pkg::PIXEL_W;

   // Configuration, held already clamped to the supported range.
   logic [WEFF_W-1:0] width_eff_ff, width_eff_in;
   logic [HGT_W-1:0]  height_eff_ff, height_eff_in;
   logic [ekc_pkg::WIDTH_REG_W-1:0] raw_w;
   logic [HGT_W-1:0] raw_h;
   logic cfg_hit;

   // Read stage.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic flush_active_ff, flush_active_in;
   logic [COL_W-1:0] flush_col_ff, flush_col_in;
   logic [COL_W-1:0] s0_col;
   ekc_pkg::item_ctl_type s0_item;
   logic s0_go;

   // Window stage.
   logic s1_valid_ff, s1_valid_in;
   ekc_pkg::item_ctl_type s1_item_ff, s1_item_in;
   logic [COL_W-1:0] s1_col_ff, s1_col_in;
   logic [PW-1:0] s1_pix_ff, s1_pix_in;
   logic s1_fire;
   logic out_free;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [ekc_pkg::SUM_W-1:0] edge_sum_ff, edge_sum_in;
   logic row_end_ff, row_end_in;
   logic frame_end_ff, frame_end_in;

   logic win_has_result;
   logic signed [ekc_pkg::SUM_W-1:0] win_sum;
   logic win_row_end, win_frame_end;

   // RAM: upper row in the high byte, middle row in the low byte.
   logic ram_we, ram_re;
   logic [2*PW-1:0] ram_wdata, ram_rdata;

   // ---------------- configuration ----------------
   assign cfg_hit = csr_we && ((csr_index == ekc_pkg::CSR_IMAGE_WIDTH)
                            || (csr_index == ekc_pkg::CSR_IMAGE_HEIGHT));
   assign raw_w = csr_wdata[ekc_pkg::WIDTH_REG_W-1:0];
   assign raw_h = csr_wdata[HGT_W-1:0];

   always_comb begin
      width_eff_in = width_eff_ff;
      height_eff_in = height_eff_ff;
      if (csr_we && (csr_index == ekc_pkg::CSR_IMAGE_WIDTH)) begin
         if (raw_w < ekc_pkg::WIDTH_REG_W'(ekc_pkg::WIDTH_MIN)) begin
            width_eff_in = WEFF_W'(ekc_pkg::WIDTH_MIN);
         end else if (raw_w > ekc_pkg::WIDTH_REG_W'(MAX_WIDTH)) begin
            width_eff_in = WEFF_W'(MAX_WIDTH);
         end else begin
            width_eff_in = WEFF_W'(raw_w);
         end
      end
      if (csr_we && (csr_index == ekc_pkg::CSR_IMAGE_HEIGHT)) begin
         if (raw_h < HGT_W'(ekc_pkg::HEIGHT_MIN)) begin
            height_eff_in = HGT_W'(ekc_pkg::HEIGHT_MIN);
         end else if (raw_h > HGT_W'(ekc_pkg::HEIGHT_MAX)) begin
            height_eff_in = HGT_W'(ekc_pkg::HEIGHT_MAX);
         end else begin
            height_eff_in = raw_h;
         end
      end
   end

   // ---------------- read stage ----------------
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire = s1_valid_ff && out_free;
   assign req_bus.ready = !flush_active_ff && (!s1_valid_ff || s1_fire);
   assign s0_go = flush_active_ff ? (!s1_valid_ff || s1_fire)
                                  : (req_bus.valid && req_bus.ready);
   assign s0_col = flush_active_ff ? flush_col_ff : col_ff;

   always_comb begin
      s0_item.flush = flush_active_ff;
      s0_item.last_col = (CMP_W'(s0_col) + CMP_W'(1)) >= CMP_W'(width_eff_ff);
      s0_item.col_odd = s0_col[0];
      s0_item.col_even_ge2 = !s0_col[0] && (s0_col[COL_W-1:1] != '0);
      if (flush_active_ff) begin
         s0_item.emit_row = 1'b1;
         s0_item.last_row = 1'b1;
      end else begin
         s0_item.emit_row = !row_ff[0] && (row_ff[ROW_W-1:1] != '0);
         s0_item.last_row = (HGT_W'(row_ff) + HGT_W'(1)) >= height_eff_ff;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      flush_active_in = flush_active_ff;
      flush_col_in = flush_col_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
         flush_active_in = 1'b0;
         flush_col_in = '0;
      end else if (s0_go && flush_active_ff) begin
         if (s0_item.last_col) begin
            flush_active_in = 1'b0;
         end else begin
            flush_col_in = flush_col_ff + COL_W'(1);
         end
      end else if (s0_go) begin
         if (s0_item.last_col) begin
            col_in = '0;
            if (s0_item.last_row) begin
               row_in = '0;
               // An even height leaves the last output row open; sweep it out.
               if (!height_eff_ff[0]) begin
                  flush_active_in = 1'b1;
                  flush_col_in = '0;
               end
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ---------------- window stage ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in = s1_item_ff;
      s1_col_in = s1_col_ff;
      s1_pix_in = s1_pix_ff;
      if (s0_go) begin
         s1_valid_in = 1'b1;
         s1_item_in = s0_item;
         s1_col_in = s0_col;
         s1_pix_in = req_bus.pixel;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Each column's entry is read as its pixel enters the window stage and rewritten as it leaves;
   // the next read of that entry is a row later, so a read never meets a pending write to it.
   assign ram_re = s0_go;
   assign ram_we = s1_fire && !s1_item_ff.flush;
   assign ram_wdata = {ram_rdata[PW-1:0], s1_pix_ff};

   ekc_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_col_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (s0_col),
      .rdata (ram_rdata)
   );

   ekc_window u_window (
      .clock      (clock),
      .advance    (s1_fire),
      .item       (s1_item_ff),
      .top_pix    (ram_rdata[2*PW-1:PW]),
      .mid_pix    (ram_rdata[PW-1:0]),
      .bot_pix    (s1_pix_ff),
      .has_result (win_has_result),
      .edge_sum   (win_sum),
      .row_end    (win_row_end),
      .frame_end  (win_frame_end)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      edge_sum_in = edge_sum_ff;
      row_end_in = row_end_ff;
      frame_end_in = frame_end_ff;
      if (s1_fire && win_has_result) begin
         rsp_valid_in = 1'b1;
         edge_sum_in = win_sum;
         row_end_in = win_row_end;
         frame_end_in = win_frame_end;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.edge_sum = edge_sum_ff;
   assign rsp_bus.row_end = row_end_ff;
   assign rsp_bus.frame_end = frame_end_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_eff_ff <= WEFF_W'(MAX_WIDTH);
         height_eff_ff <= HGT_W'(ekc_pkg::RESET_HEIGHT);
         col_ff <= '0;
         row_ff <= '0;
         flush_active_ff <= 1'b0;
         flush_col_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_eff_ff <= width_eff_in;
         height_eff_ff <= height_eff_in;
         col_ff <= col_in;
         row_ff <= row_in;
         flush_active_ff <= flush_active_in;
         flush_col_ff <= flush_col_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_col_ff <= s1_col_in;
      s1_pix_ff <= s1_pix_in;
      edge_sum_ff <= edge_sum_in;
      row_end_ff <= row_end_in;
      frame_end_ff <= frame_end_in;
   end

   // ---------------- assertions ----------------
   a_frame_end_closes_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |-> row_end_ff)
      else $error("frame_end without row_end");

   a_sweep_counters_idle: assert property (@(posedge clock) disable iff (reset)
      flush_active_ff |-> ((col_ff == '0) && (row_ff == '0)))
      else $error("pixel counters moved during end-of-frame sweep");

   a_sweep_starts_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(flush_active_ff) |-> ($past(s0_go) && $past(s0_item.last_col)
                                  && $past(s0_item.last_row)))
      else $error("end-of-frame sweep started away from the last pixel");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      (s0_go && !flush_active_ff && s0_item.last_col && s0_item.last_row)
      |=> ((col_ff == '0) && (row_ff == '0)))
      else $error("counters did not wrap after the frame's last pixel");

endmodule

`default_nettype wire

>>> dv/tb_edge_kernel_conv3x3_stride2.sv
// Self-checking testbench for the stride-2 3x3 edge convolver: it streams pixel frames of many
// sizes, predicts every edge result in step with the stream and checks the result stream.
// Depends on ekc_pkg and the stream interfaces in hdl/.
`timescale 1ns / 1ps

module tb_edge_kernel_conv3x3_stride2;

   localparam int RUN_LIMIT = 1_000_000;
   localparam int LINE_MAX = ekc_pkg::MAX_WIDTH_DEFAULT;
   localparam int SETTLE_CYCLES = LINE_MAX + 8;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_PIXELS = 40;
   localparam int RANDOM_EDGES = 10;
   localparam int LONG_HOLD = 300;
   localparam logic [ekc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW = ekc_pkg::CSR_INDEX_W'(2);
   localparam logic [ekc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = ekc_pkg::CSR_INDEX_W'(3);
   localparam int EDGE_WEIGHTS [3][3] = '{'{-1, 1, 1}, '{-1, 0, 1}, '{-1, -1, 1}};

   typedef struct packed {
      logic signed [ekc_pkg::SUM_W-1:0] edge_sum;
      logic row_end;
      logic frame_end;
   } edge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [ekc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ekc_pkg::CSR_DATA_W-1:0] csr_wdata;

   ekc_pix_if pix_bus ();
   ekc_res_if res_bus ();

   // Predictor state.
   ekc_pkg::pixel_type line_upper [LINE_MAX];
   ekc_pkg::pixel_type line_middle [LINE_MAX];
   ekc_pkg::column_type left_column;
   ekc_pkg::column_type center_column;
   int unsigned column_pos;
   int unsigned row_pos;
   logic [ekc_pkg::WIDTH_REG_W-1:0] width_reg;
   logic [ekc_pkg::HEIGHT_REG_W-1:0] height_reg;
   edge_result_type pending_edges [$];
   edge_result_type oldest_edge;

   int unsigned failures;
   int unsigned pixels_sent;
   int unsigned edges_predicted;
   int unsigned edges_checked;
   int unsigned csr_writes;
   int unsigned cycle_count = 0;

   // Flow control of both sides.
   bit sender_steady;
   bit receiver_steady;
   int unsigned hold_requests;
   int unsigned hold_length;
   int unsigned holds_seen = 0;
   int stall_left = 0;
   int stall_roll;

   edge_kernel_conv3x3_stride2 u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (pix_bus),
      .rsp_bus   (res_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  pending_edges.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int unsigned frame_width();
      if (width_reg < ekc_pkg::WIDTH_MIN) return ekc_pkg::WIDTH_MIN;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
   endfunction

   function automatic int unsigned frame_height();
      if (height_reg < ekc_pkg::HEIGHT_MIN) return ekc_pkg::HEIGHT_MIN;
      if (height_reg > ekc_pkg::HEIGHT_MAX) return ekc_pkg::HEIGHT_MAX;
      return height_reg;
   endfunction

   function automatic int kernel_response(input ekc_pkg::column_type lft,
                                          input ekc_pkg::column_type mid,
                                          input ekc_pkg::column_type rgt);
      int acc;
      int r;
      acc = 0;
      for (r = 0; r < 3; r++) begin
         acc += EDGE_WEIGHTS[r][0] * int'(lft[r]) + EDGE_WEIGHTS[r][1] * int'(mid[r])
              + EDGE_WEIGHTS[r][2] * int'(rgt[r]);
      end
      return acc;
   endfunction

   function automatic void queue_edge(input int sum, input logic re, input logic fe);
      edge_result_type item;
      item.edge_sum = sum[ekc_pkg::SUM_W-1:0];
      item.row_end = re;
      item.frame_end = fe;
      pending_edges.push_back(item);
      edges_predicted++;
   endfunction

   function automatic void restart_frame();
      column_pos = 0;
      row_pos = 0;
      left_column = '0;
      center_column = '0;
   endfunction

   function automatic void apply_csr_write(input logic [ekc_pkg::CSR_INDEX_W-1:0] index,
                                           input logic [ekc_pkg::CSR_DATA_W-1:0] data);
      case (index)
         ekc_pkg::CSR_IMAGE_WIDTH: begin
            width_reg = data[ekc_pkg::WIDTH_REG_W-1:0];
            restart_frame();
         end
         ekc_pkg::CSR_IMAGE_HEIGHT: begin
            height_reg = data[ekc_pkg::HEIGHT_REG_W-1:0];
            restart_frame();
         end
         default: ;
      endcase
   endfunction

   // Works out the results that one accepted pixel releases.
   function automatic void predict_edges(input ekc_pkg::pixel_type pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned j;
      logic last_col;
      logic last_row;
      logic band_end;
      ekc_pkg::column_type cur;
      ekc_pkg::column_type lft;
      ekc_pkg::column_type mid;
      ekc_pkg::column_type rgt;
      w = frame_width();
      h = frame_height();
      c = column_pos % LINE_MAX;
      r = row_pos;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      cur[0] = line_upper[c];
      cur[1] = line_middle[c];
      cur[2] = pix;
      line_upper[c] = cur[1];
      line_middle[c] = cur[2];
      if (r >= 2 && (r % 2) == 0) begin
         if (c >= 2 && (c % 2) == 0) begin
            queue_edge(kernel_response(left_column, center_column, cur), last_col,
                       last_col && last_row);
         end else if (last_col && (c % 2) == 1) begin
            // Even width: the last window has nothing to its right.
            queue_edge(kernel_response(center_column, cur, '0), 1'b1, last_row);
         end
      end
      left_column = center_column;
      center_column = cur;
      // Even height: the final pixel releases the whole bottom output row.
      if (last_col && last_row && (h % 2) == 0) begin
         for (j = 1; j < w; j += 2) begin
            lft = '0;
            mid = '0;
            rgt = '0;
            lft[0] = line_upper[j - 1];
            lft[1] = line_middle[j - 1];
            mid[0] = line_upper[j];
            mid[1] = line_middle[j];
            if (j + 1 < w) begin
               rgt[0] = line_upper[j + 1];
               rgt[1] = line_middle[j + 1];
            end
            band_end = (j + 2 >= w);
            queue_edge(kernel_response(lft, mid, rgt), band_end, band_end);
         end
      end
      if (last_col) begin
         column_pos = 0;
         row_pos = last_row ? 0 : (r + 1) % 1024;
      end else begin
         column_pos = (c + 1) % LINE_MAX;
      end
   endfunction

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, what);
      end
   endfunction

   // Result checker.
   always @(posedge clock) begin
      if (!reset && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
         edges_checked++;
         if (pending_edges.size() == 0) begin
            note_failure($sformatf("Unexpected result: sum %0d row_end %0b frame_end %0b",
                                   res_bus.edge_sum, res_bus.row_end, res_bus.frame_end));
         end else begin
            oldest_edge = pending_edges.pop_front();
            if (res_bus.edge_sum !== oldest_edge.edge_sum
                || res_bus.row_end !== oldest_edge.row_end
                || res_bus.frame_end !== oldest_edge.frame_end) begin
               note_failure($sformatf(
                  "Result %0d: expected sum %0d row_end %0b frame_end %0b, got %0d %0b %0b",
                  edges_checked, oldest_edge.edge_sum, oldest_edge.row_end,
                  oldest_edge.frame_end, res_bus.edge_sum, res_bus.row_end,
                  res_bus.frame_end));
            end
         end
      end
   end

   // Result receiver: random stalls, plus a long hold whenever the test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         res_bus.ready <= 1'b0;
      end else begin
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            stall_left = hold_length;
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_bus.ready <= 1'b0;
         end else if (receiver_steady) begin
            res_bus.ready <= 1'b1;
         end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
               res_bus.ready <= 1'b1;
            end else begin
               res_bus.ready <= 1'b0;
               stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
         end
      end
   end

   function automatic int sender_gap();
      int roll;
      if (sender_steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic ekc_pkg::pixel_type random_pixel();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return ekc_pkg::pixel_type'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel(input ekc_pkg::pixel_type pix);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         pix_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_bus.valid <= 1'b1;
      pix_bus.pixel <= pix;
      @(posedge clock);
      while (pix_bus.ready !== 1'b1) @(posedge clock);
      predict_edges(pix);
      pixels_sent++;
   endtask

   task automatic send_random_pixels(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   task automatic wait_drained();
      pix_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_edges.size() != 0) @(posedge clock);
   endtask

   // The block must be idle; a pixel that releases no result may still be in flight.
   task automatic write_csr(input logic [ekc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ekc_pkg::CSR_DATA_W-1:0] data);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr_write(index, data);
      csr_writes++;
      csr_we <= 1'b0;
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      write_csr(ekc_pkg::CSR_IMAGE_WIDTH, ekc_pkg::CSR_DATA_W'(w));
      write_csr(ekc_pkg::CSR_IMAGE_HEIGHT, ekc_pkg::CSR_DATA_W'(h));
   endtask

   // Only the width is narrowed, so the height keeps its reset size and row 2 is never the
   // last row of the frame.
   task automatic test_reset_values();
      write_csr(ekc_pkg::CSR_IMAGE_WIDTH, ekc_pkg::CSR_DATA_W'(5));
      send_random_pixels(3 * 5);
   endtask

   task automatic test_kernel_extremes();
      ekc_pkg::pixel_type rising [9];
      ekc_pkg::pixel_type falling [6];
      ekc_pkg::pixel_type corner [4];
      rising = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd77, 8'd255, 8'd0, 8'd0, 8'd255};
      falling = '{8'd255, 8'd0, 8'd255, 8'd13, 8'd255, 8'd255};
      corner = '{8'd0, 8'd255, 8'd0, 8'd128};
      set_geometry(3, 3);
      foreach (rising[i]) send_pixel(rising[i]);
      // Width 2 with an odd height: the only window sits on the right edge.
      set_geometry(2, 3);
      foreach (falling[i]) send_pixel(falling[i]);
      // Smallest frame: its one result comes from the bottom flush.
      set_geometry(2, 2);
      foreach (corner[i]) send_pixel(corner[i]);
   endtask

   task automatic test_register_clamping();
      // A height below the minimum acts as two rows, so the bottom flush follows row 1.
      set_geometry(4, 1);
      send_random_pixels(4 * ekc_pkg::HEIGHT_MIN);
      // Partial frame at the narrowest width and the tallest height; the next write restarts it.
      set_geometry(1, 11'h7FF);
      send_random_pixels(ekc_pkg::WIDTH_MIN * 6);
      set_geometry(0, 0);
      send_random_pixels(ekc_pkg::WIDTH_MIN * ekc_pkg::HEIGHT_MIN);
   endtask

   task automatic test_ignored_index();
      set_geometry(5, 7);
      send_random_pixels(12);
      write_csr(CSR_SPARE_LOW, ekc_pkg::CSR_DATA_W'($urandom));
      write_csr(CSR_SPARE_HIGH, '1);
      send_random_pixels(5 * 7 - 12);
   endtask

   task automatic test_output_backpressure();
      set_geometry(4, 8);
      sender_steady = 1'b1;
      hold_length <= LONG_HOLD;
      hold_requests <= hold_requests + 1;
      send_random_pixels(16);
      wait_drained();
      sender_steady = 1'b0;
      send_random_pixels(16);
   endtask

   task automatic test_random_frames();
      int unsigned start_pixels;
      int unsigned start_edges;
      int unsigned w;
      int unsigned h;
      int unsigned frame_pixels;
      int unsigned count;
      logic complete;
      start_pixels = pixels_sent;
      start_edges = edges_predicted;
      complete = 1'b0;
      w = 2;
      h = 2;
      while (pixels_sent - start_pixels < RANDOM_PIXELS
             || edges_predicted - start_edges < RANDOM_EDGES) begin
         // After a whole frame the next one may follow with no restart.
         if (!complete || $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 9) == 0) begin
               w = $urandom_range(12, 16);
               h = $urandom_range(2, 3);
            end else begin
               w = $urandom_range(2, 10);
               h = $urandom_range(2, 8);
            end
            set_geometry(w, h);
         end
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady <= ($urandom_range(0, 3) == 0);
         frame_pixels = w * h;
         count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_pixels - 1)
                                             : frame_pixels;
         complete = (count == frame_pixels);
         send_random_pixels(count);
      end
      sender_steady = 1'b0;
      receiver_steady <= 1'b0;
   endtask

   initial begin
      csr_we = 1'b0;
      csr_index = ekc_pkg::CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      pix_bus.valid = 1'b0;
      pix_bus.pixel = '0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      hold_requests = 0;
      hold_length = 0;
      failures = 0;
      pixels_sent = 0;
      edges_predicted = 0;
      edges_checked = 0;
      csr_writes = 0;
      width_reg = ekc_pkg::WIDTH_REG_W'(LINE_MAX);
      height_reg = ekc_pkg::HEIGHT_REG_W'(ekc_pkg::RESET_HEIGHT);
      foreach (line_upper[i]) begin
         line_upper[i] = '0;
         line_middle[i] = '0;
      end
      restart_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_kernel_extremes();
      test_register_clamping();
      test_ignored_index();
      test_output_backpressure();
      test_random_frames();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d pixels and checked %0d results across %0d register writes,", pixels_sent,
               edges_checked, csr_writes);
      $display("covering clamped sizes, edge flushes, long output stalls and input stalls.");
      if (failures == 0 && pending_edges.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
